// ----- hdl/ascii_hex_frame_receiver_assert.svh -----
// Assertion macros shared by the receiver's RTL modules.
// Needs signals aclk and aresetn in the scope that uses them.
`ifndef ASCII_HEX_FRAME_RECEIVER_ASSERT_SVH
`define ASCII_HEX_FRAME_RECEIVER_ASSERT_SVH

// Same-cycle implication, disabled while in reset.
`define AHFR_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while in reset.
`define AHFR_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- hdl/ahfr_pkg.sv -----
// Package for the ASCII-hex frame receiver: types, codes and constants.
// No dependencies; imported by every module of the block.
package ahfr_pkg;

    localparam int MAX_PAYLOAD = 128;
    localparam int QDEPTH      = 4;
    localparam int QPTR_W      = $clog2(QDEPTH);
    localparam int QCNT_W      = $clog2(QDEPTH + 1);

    // Character bounds for uppercase hex digits
    localparam logic [7:0] CH_BELOW_0 = 8'h2f;
    localparam logic [7:0] CH_ABOVE_9 = 8'h3a;
    localparam logic [7:0] CH_BELOW_A = 8'h40;
    localparam logic [7:0] CH_ABOVE_F = 8'h47;
    localparam logic [7:0] CH_ZERO    = 8'h30;
    localparam logic [7:0] CH_A_OFS   = 8'h37;

    localparam logic [7:0] RST_START_CHAR = 8'h02;
    localparam logic [7:0] RST_END_CHAR   = 8'h03;

    typedef enum logic [1:0] {
        REG_START_CHAR = 2'd0,
        REG_END_CHAR   = 2'd1,
        REG_STATION    = 2'd2,
        REG_RD_CMD     = 2'd3
    } reg_idx_t;

    typedef enum logic [1:0] {
        ST_NONE   = 2'd0,
        ST_BYTE   = 2'd1,
        ST_REJECT = 2'd2,
        ST_DONE   = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        PH_HUNT    = 2'd0,
        PH_PAYLOAD = 2'd1,
        PH_CSUM    = 2'd2
    } phase_t;

    typedef struct packed {
        logic [7:0]  start_char;
        logic [7:0]  end_char;
        logic [15:0] station_address;
        logic [15:0] read_address_command;
    } cfg_t;

    // Classified character as it travels from front to back
    typedef struct packed {
        logic       is_hex;
        logic [3:0] digit;
        logic       is_end;
        logic       is_start;
    } class_t;

    typedef struct packed {
        status_t     status;
        logic [7:0]  byte_value;
        logic [6:0]  byte_index;
        logic [15:0] checksum;
        logic [7:0]  frame_length;
    } result_t;

endpackage

// ----- hdl/ahfr_front.sv -----
// Front end: configuration registers and per-character classification.
// Depends on ahfr_pkg.
module ahfr_front
    import ahfr_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data,
    input  logic [7:0]  rx_byte,
    output class_t      cls,
    output cfg_t        cfg
);

    cfg_t cfg_reg;

    assign cfg_ready = 1'b1;
    assign cfg       = cfg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.start_char           <= RST_START_CHAR;
            cfg_reg.end_char             <= RST_END_CHAR;
            cfg_reg.station_address      <= '0;
            cfg_reg.read_address_command <= '0;
        end else if (cfg_valid) begin
            unique case (reg_idx_t'(cfg_index))
                REG_START_CHAR: cfg_reg.start_char           <= cfg_data[7:0];
                REG_END_CHAR:   cfg_reg.end_char             <= cfg_data[7:0];
                REG_STATION:    cfg_reg.station_address      <= cfg_data;
                REG_RD_CMD:     cfg_reg.read_address_command <= cfg_data;
                default: ;
            endcase
        end
    end

    logic is_num, is_alpha;
    logic [7:0] num_val, alpha_val;

    always_comb begin
        is_num    = (rx_byte > CH_BELOW_0) && (rx_byte < CH_ABOVE_9);
        is_alpha  = (rx_byte > CH_BELOW_A) && (rx_byte < CH_ABOVE_F);
        num_val   = rx_byte - CH_ZERO;
        alpha_val = rx_byte - CH_A_OFS;
        cls.is_hex   = is_num || is_alpha;
        cls.digit    = is_num ? num_val[3:0] : alpha_val[3:0];
        cls.is_end   = (rx_byte == cfg_reg.end_char);
        cls.is_start = (rx_byte == cfg_reg.start_char);
    end

endmodule

// ----- hdl/ahfr_queue.sv -----
// Short FIFO of classified characters between front and back.
// Depends on ahfr_pkg and the assertion macro header.
`include "ascii_hex_frame_receiver_assert.svh"

module ahfr_queue
    import ahfr_pkg::*;
(
    input  logic   aclk,
    input  logic   aresetn,
    input  logic   push,
    input  class_t wr_data,
    output logic   full,
    input  logic   pop,
    output logic   not_empty,
    output class_t rd_data
);

    class_t             mem [QDEPTH];
    logic [QPTR_W-1:0]  wr_ptr_reg, rd_ptr_reg;
    logic [QCNT_W-1:0]  count_reg, count_next;

    assign full      = (count_reg == QCNT_W'(QDEPTH));
    assign not_empty = (count_reg != '0);
    assign rd_data   = mem[rd_ptr_reg];

    always_comb begin
        count_next = count_reg;
        if (push && !pop) count_next = count_reg + 1'b1;
        if (pop && !push) count_next = count_reg - 1'b1;
    end

    always_ff @(posedge aclk) begin
        if (push) mem[wr_ptr_reg] <= wr_data;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) wr_ptr_reg <= wr_ptr_reg + 1'b1;
            if (pop)  rd_ptr_reg <= rd_ptr_reg + 1'b1;
            count_reg <= count_next;
        end
    end

    `AHFR_ASSERT_NOW(a_no_pop_empty, pop, count_reg != '0, "pop from empty queue")
    `AHFR_ASSERT_NOW(a_no_push_full, push, !full, "push into full queue")
    `AHFR_ASSERT_NEXT(a_count_hold, push && pop, $stable(count_reg), "count moved on push+pop")

endmodule

// ----- hdl/ahfr_back.sv -----
// Back end: frame state machine and registered result stage.
// Depends on ahfr_pkg and the assertion macro header.
`include "ascii_hex_frame_receiver_assert.svh"

module ahfr_back
    import ahfr_pkg::*;
(
    input  logic    aclk,
    input  logic    aresetn,
    input  cfg_t    cfg,
    input  logic    q_not_empty,
    input  class_t  q_data,
    output logic    q_pop,
    output logic    out_valid,
    input  logic    out_ready,
    output result_t out_data
);

    phase_t     phase_reg, phase_next;
    logic       nib_reg, nib_next;
    logic [3:0] high_reg, high_next;
    logic [7:0] count_reg, count_next;
    logic       ccount_reg, ccount_next;
    logic [7:0] chigh_reg, chigh_next;
    logic [7:0] hdr_reg [5];
    logic       hdr_we;

    logic       out_valid_reg;
    result_t    out_reg, res;
    logic [7:0] b;

    // Checker terms: fields that must stay zero outside their status, and a pop while hunting
    logic       byte_stray, done_stray, hunt_pop;

    assign q_pop     = q_not_empty && (!out_valid_reg || out_ready);
    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    always_comb begin
        phase_next  = phase_reg;
        nib_next    = nib_reg;
        high_next   = high_reg;
        count_next  = count_reg;
        ccount_next = ccount_reg;
        chigh_next  = chigh_reg;
        hdr_we      = 1'b0;
        res         = '0;
        res.status  = ST_NONE;
        b           = {high_reg, q_data.digit};

        unique case (phase_reg)
            PH_PAYLOAD: begin
                if (!q_data.is_hex) begin
                    if (q_data.is_end) begin
                        phase_next  = PH_CSUM;
                        nib_next    = 1'b0;
                        ccount_next = 1'b0;
                    end else begin
                        phase_next = PH_HUNT;
                        nib_next   = 1'b0;
                        res.status = ST_REJECT;
                    end
                end else if (!nib_reg) begin
                    high_next = q_data.digit;
                    nib_next  = 1'b1;
                end else begin
                    nib_next = 1'b0;
                    if (count_reg >= 8'(MAX_PAYLOAD)) begin
                        phase_next = PH_HUNT;
                        res.status = ST_REJECT;
                    end else begin
                        hdr_we     = (count_reg < 8'd5);
                        count_next = count_reg + 8'd1;
                        // Sender address must be zero; receiver must match
                        // unless the command is the read-address command.
                        if ((count_reg == 8'd1) &&
                            ((hdr_reg[0] != 8'd0) || (b != 8'd0))) begin
                            phase_next = PH_HUNT;
                            res.status = ST_REJECT;
                        end else if ((count_reg == 8'd5) &&
                            ({hdr_reg[2], hdr_reg[3]} != cfg.station_address) &&
                            ({hdr_reg[4], b} != cfg.read_address_command)) begin
                            phase_next = PH_HUNT;
                            res.status = ST_REJECT;
                        end else begin
                            res.status     = ST_BYTE;
                            res.byte_value = b;
                            res.byte_index = count_reg[6:0];
                        end
                    end
                end
            end
            PH_CSUM: begin
                if (!q_data.is_hex) begin
                    phase_next = PH_HUNT;
                    nib_next   = 1'b0;
                    res.status = ST_REJECT;
                end else if (!nib_reg) begin
                    high_next = q_data.digit;
                    nib_next  = 1'b1;
                end else begin
                    nib_next = 1'b0;
                    if (!ccount_reg) begin
                        chigh_next  = b;
                        ccount_next = 1'b1;
                    end else begin
                        ccount_next      = 1'b0;
                        phase_next       = PH_HUNT;
                        res.status       = ST_DONE;
                        res.checksum     = {chigh_reg, b};
                        res.frame_length = count_reg;
                    end
                end
            end
            default: begin
                phase_next = PH_HUNT;
                if (q_data.is_start) begin
                    phase_next = PH_PAYLOAD;
                    nib_next   = 1'b0;
                    count_next = 8'd0;
                end
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg  <= PH_HUNT;
            nib_reg    <= 1'b0;
            high_reg   <= '0;
            count_reg  <= '0;
            ccount_reg <= 1'b0;
            chigh_reg  <= '0;
        end else if (q_pop) begin
            phase_reg  <= phase_next;
            nib_reg    <= nib_next;
            high_reg   <= high_next;
            count_reg  <= count_next;
            ccount_reg <= ccount_next;
            chigh_reg  <= chigh_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (q_pop && hdr_we) hdr_reg[count_reg[2:0]] <= b;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (q_pop) begin
            out_valid_reg <= 1'b1;
        end else if (out_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (q_pop) out_reg <= res;
    end

    assign byte_stray = (out_reg.status != ST_BYTE) &&
                        ((out_reg.byte_value != 8'd0) || (out_reg.byte_index != 7'd0));
    assign done_stray = (out_reg.status != ST_DONE) &&
                        ((out_reg.checksum != 16'd0) || (out_reg.frame_length != 8'd0));
    assign hunt_pop   = q_pop && (phase_reg == PH_HUNT);

    `AHFR_ASSERT_NOW(a_byte_fields, out_valid_reg, !byte_stray, "stray byte fields")
    `AHFR_ASSERT_NOW(a_done_fields, out_valid_reg, !done_stray, "stray frame fields")
    `AHFR_ASSERT_NEXT(a_hunt_silent, hunt_pop, out_reg.status == ST_NONE, "result while hunting")

endmodule

// ----- hdl/ascii_hex_frame_receiver.sv -----
// ASCII-hex frame receiver, top level.
// Depends on ahfr_pkg, ahfr_front, ahfr_queue and ahfr_back.
//
// Usage:
// - s_* is the character input: one received byte per word on s_tdata[7:0].
// - m_* gives exactly one result word for every input word, in order:
//   m_tuser carries the status (nothing, payload byte, frame rejected,
//   frame complete), m_tdata the byte value, byte index, checksum and
//   frame length (zero where the status gives them no meaning).
// - cfg_* writes the start and end characters, the station address and the
//   read-address command; write only while no word is in flight.
// Path: an accepted word is written into the queue, popped by the back
// and registered in the result stage, which drives m_*. One word per
// cycle sustained while m_tready is high: the front classifies a
// character combinationally, the back runs the frame state machine once
// per popped word. A four-deep queue separates the two, and the back's
// result register holds its word while m_tready is low; the queue then
// fills and s_tready drops, so nothing is lost under any stall pattern.
// Reset (aresetn low, synchronous) empties the queue and result stage,
// puts the frame logic back to hunting and loads the default registers.
// Every rejection or completed frame also returns to hunting.
module ascii_hex_frame_receiver
    import ahfr_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] rx_byte
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,   // [7:0] byte_value, [14:8] byte_index,
                                   // [30:15] checksum, [38:31] frame_length
    output logic [1:0]  m_tuser,   // [1:0] status
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data
);

    class_t  cls, q_data;
    cfg_t    cfg;
    logic    q_full, q_not_empty, q_pop, push;
    result_t res;

    // Take a word whenever the queue has room
    assign s_tready = !q_full;
    assign push     = s_tvalid && s_tready;

    ahfr_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .rx_byte   (s_tdata),
        .cls       (cls),
        .cfg       (cfg)
    );

    ahfr_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .wr_data   (cls),
        .full      (q_full),
        .pop       (q_pop),
        .not_empty (q_not_empty),
        .rd_data   (q_data)
    );

    ahfr_back u_back (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg         (cfg),
        .q_not_empty (q_not_empty),
        .q_data      (q_data),
        .q_pop       (q_pop),
        .out_valid   (m_tvalid),
        .out_ready   (m_tready),
        .out_data    (res)
    );

    // Pack the result; pad the top bit of tdata with zero
    assign m_tuser = res.status;
    assign m_tdata = {1'b0, res.frame_length, res.checksum, res.byte_index, res.byte_value};

endmodule

// ----- tb/ascii_hex_frame_receiver_tb.sv -----
`timescale 1ns / 100ps
// Self-checking testbench for the ASCII-hex frame receiver: directed table, then random frames.
// Depends on ahfr_pkg and the ascii_hex_frame_receiver RTL; nothing else.
module ascii_hex_frame_receiver_tb;
    import ahfr_pkg::*;

    localparam int ITEM_TARGET = 2000;
    localparam int PHASE_ITEMS = 250;
    localparam int QUIET_ITEMS = 300;
    localparam int N_DIRECTED  = 26;

    localparam result_t NOTHING  = '{ST_NONE, 8'h00, 7'd0, 16'h0000, 8'd0};
    localparam result_t REJECTED = '{ST_REJECT, 8'h00, 7'd0, 16'h0000, 8'd0};

    // One row of the directed table: the character, and an expectation that
    // is used instead of the predictor when typed is set.
    typedef struct packed {
        logic [7:0] ch;
        logic       typed;
        result_t    want;
    } directed_row_t;

    localparam directed_row_t DIRECTED_ROWS [N_DIRECTED] = '{
        '{8'hFF, 1'b1, NOTHING},        // all ones while hunting: ignored
        '{8'h02, 1'b1, NOTHING},        // default start character opens a frame
        // six zero header bytes: sender zero, receiver matches station zero
        '{8'h30, 1'b0, NOTHING}, '{8'h30, 1'b0, NOTHING},
        '{8'h30, 1'b0, NOTHING}, '{8'h30, 1'b0, NOTHING},
        '{8'h30, 1'b0, NOTHING}, '{8'h30, 1'b0, NOTHING},
        '{8'h30, 1'b0, NOTHING}, '{8'h30, 1'b0, NOTHING},
        '{8'h30, 1'b0, NOTHING}, '{8'h30, 1'b0, NOTHING},
        '{8'h30, 1'b0, NOTHING}, '{8'h30, 1'b0, NOTHING},
        '{8'h46, 1'b0, NOTHING},
        '{8'h46, 1'b1, '{ST_BYTE, 8'hFF, 7'd6, 16'h0000, 8'd0}},
        '{8'h41, 1'b0, NOTHING},        // lone high nibble, dropped at the end character
        '{8'h03, 1'b1, NOTHING},
        '{8'h46, 1'b0, NOTHING}, '{8'h46, 1'b0, NOTHING},
        '{8'h30, 1'b0, NOTHING},
        '{8'h30, 1'b1, '{ST_DONE, 8'h00, 7'd0, 16'hFF00, 8'd7}},
        '{8'h02, 1'b0, NOTHING},
        '{8'h61, 1'b1, REJECTED},       // lowercase digit is illegal
        '{8'h02, 1'b0, NOTHING},
        '{8'h02, 1'b1, REJECTED}        // start character inside the payload
    };

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [7:0]  s_tdata;    // [7:0] rx_byte
    logic        m_tvalid;
    logic        m_tready;
    logic [39:0] m_tdata;    // [7:0] byte_value, [14:8] byte_index,
                             // [30:15] checksum, [38:31] frame_length
    logic [1:0]  m_tuser;    // [1:0] status
    logic        cfg_valid;
    logic        cfg_ready;
    logic [1:0]  cfg_index;
    logic [15:0] cfg_data;

    // Predictor state: mirrors the frame logic and its registers
    phase_t      fr_phase;
    logic        nib_held;
    logic [3:0]  hi_nib;
    logic [7:0]  pay_count;
    logic [7:0]  hdr_bytes [6];
    logic        sum_half;
    logic [7:0]  sum_high;
    logic [7:0]  cfg_start;
    logic [7:0]  cfg_end;
    logic [15:0] cfg_station;
    logic [15:0] cfg_rdcmd;

    result_t     due_results [$];
    result_t     oldest_result;
    int          mismatches;
    int          chars_counted;
    int          tx_idle_pct;
    int          rx_stall_pct;
    logic        quiet_tail;
    int          phase_no;
    int          phase_base;
    logic [7:0]  new_start;
    logic [7:0]  new_end;
    logic [15:0] new_station;
    logic [15:0] new_rdcmd;

    ascii_hex_frame_receiver dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // Hard stop: far beyond the slowest legal run with every stall at its longest
    initial begin
        #5_000_000;
        $display("*** FAILED ***");
        $finish;
    end

    // Work out the result of one accepted character and advance the frame state.
    function automatic result_t decode_char(input logic [7:0] c);
        result_t    r;
        logic       is_hex;
        logic [3:0] dig;
        logic [7:0] b;
        logic       hdr_ok;
        r      = NOTHING;
        is_hex = (c >= 8'h30 && c <= 8'h39) || (c >= 8'h41 && c <= 8'h46);
        dig    = (c <= 8'h39) ? 4'(c - 8'h30) : 4'(c - 8'h37);
        case (fr_phase)
            PH_PAYLOAD: begin
                if (!is_hex) begin
                    // a digit wins over the end character, so test this only here
                    if (c == cfg_end) begin
                        fr_phase = PH_CSUM;
                        nib_held = 1'b0;
                        sum_half = 1'b0;
                    end else begin
                        fr_phase = PH_HUNT;
                        nib_held = 1'b0;
                        r        = REJECTED;
                    end
                end else if (!nib_held) begin
                    hi_nib   = dig;
                    nib_held = 1'b1;
                end else begin
                    nib_held = 1'b0;
                    b        = {hi_nib, dig};
                    if (pay_count >= MAX_PAYLOAD) begin
                        fr_phase = PH_HUNT;
                        r        = REJECTED;
                    end else begin
                        r.byte_index = pay_count[6:0];
                        if (pay_count < 6) hdr_bytes[pay_count] = b;
                        pay_count = pay_count + 8'd1;
                        hdr_ok    = 1'b1;
                        // short frames skip the checks they never reach
                        if (pay_count == 8'd2)
                            hdr_ok = (hdr_bytes[0] == 8'h00) && (hdr_bytes[1] == 8'h00);
                        else if (pay_count == 8'd6)
                            hdr_ok = ({hdr_bytes[2], hdr_bytes[3]} == cfg_station) ||
                                     ({hdr_bytes[4], hdr_bytes[5]} == cfg_rdcmd);
                        if (hdr_ok) begin
                            r.status     = ST_BYTE;
                            r.byte_value = b;
                        end else begin
                            fr_phase = PH_HUNT;
                            r        = REJECTED;
                        end
                    end
                end
            end
            PH_CSUM: begin
                if (!is_hex) begin
                    fr_phase = PH_HUNT;
                    nib_held = 1'b0;
                    r        = REJECTED;
                end else if (!nib_held) begin
                    hi_nib   = dig;
                    nib_held = 1'b1;
                end else begin
                    nib_held = 1'b0;
                    b        = {hi_nib, dig};
                    if (!sum_half) begin
                        sum_high = b;
                        sum_half = 1'b1;
                    end else begin
                        sum_half       = 1'b0;
                        fr_phase       = PH_HUNT;
                        r.status       = ST_DONE;
                        r.checksum     = {sum_high, b};
                        r.frame_length = pay_count;
                    end
                end
            end
            default: begin
                // hunting; the unused phase code behaves the same way
                fr_phase = PH_HUNT;
                if (c == cfg_start) begin
                    fr_phase  = PH_PAYLOAD;
                    nib_held  = 1'b0;
                    pay_count = 8'd0;
                end
            end
        endcase
        return r;
    endfunction

    function automatic logic [7:0] hex_char(input logic [3:0] n);
        return (n < 4'd10) ? 8'h30 + {4'h0, n} : 8'h37 + {4'h0, n};
    endfunction

    task automatic report_mismatch(input string field, input logic [39:0] got,
                                   input logic [39:0] want);
        mismatches++;
        $display("%0t ns: %s mismatch, got 0x%0h, expected 0x%0h",
                 $time, field, got, want);
    endtask

    // Compare every accepted result word with the oldest expectation.
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            if (due_results.size() == 0) begin
                report_mismatch("unexpected word", m_tdata, 40'h0);
            end else begin
                oldest_result = due_results.pop_front();
                if (m_tuser != oldest_result.status)
                    report_mismatch("status", m_tuser, oldest_result.status);
                if (m_tdata[7:0] != oldest_result.byte_value)
                    report_mismatch("byte_value", m_tdata[7:0], oldest_result.byte_value);
                if (m_tdata[14:8] != oldest_result.byte_index)
                    report_mismatch("byte_index", m_tdata[14:8], oldest_result.byte_index);
                if (m_tdata[30:15] != oldest_result.checksum)
                    report_mismatch("checksum", m_tdata[30:15], oldest_result.checksum);
                if (m_tdata[38:31] != oldest_result.frame_length)
                    report_mismatch("frame_length", m_tdata[38:31],
                                    oldest_result.frame_length);
            end
        end
    end

    // Result side back-pressure: random stall bursts, none in the quiet tail.
    initial begin
        m_tready = 1'b0;
        @(posedge aresetn);
        forever begin
            @(negedge aclk);
            if (rx_stall_pct != 0 && $urandom_range(0, 99) < rx_stall_pct) begin
                m_tready = 1'b0;
                repeat ($urandom_range(1, 12)) @(negedge aclk);
            end
            m_tready = 1'b1;
        end
    end

    // Offer one character, hold it until accepted, then queue its expectation.
    // Entered and left at a falling edge; valid stays high between words except during an idle gap.
    task automatic send_word(input logic [7:0] ch, input logic use_typed,
                             input result_t typed_want);
        result_t predicted;
        if (!quiet_tail && tx_idle_pct != 0 && $urandom_range(0, 99) < tx_idle_pct) begin
            s_tvalid = 1'b0;
            repeat ($urandom_range(1, 12)) @(negedge aclk);
        end
        s_tvalid = 1'b1;
        s_tdata  = ch;
        do @(posedge aclk); while (!s_tready);
        chars_counted++;
        predicted = decode_char(ch);
        due_results.push_back(use_typed ? typed_want : predicted);
        @(negedge aclk);
    endtask

    task automatic send_hex_byte(input logic [7:0] b);
        logic [7:0] hi_ch;
        logic [7:0] lo_ch;
        hi_ch = hex_char(b[7:4]);
        lo_ch = hex_char(b[3:0]);
        // rare line noise: replace a digit with any byte
        if ($urandom_range(0, 199) == 0) hi_ch = 8'($urandom);
        if ($urandom_range(0, 199) == 0) lo_ch = 8'($urandom);
        send_word(hi_ch, 1'b0, NOTHING);
        send_word(lo_ch, 1'b0, NOTHING);
    endtask

    // One frame under the current registers: mostly a good header, sometimes a
    // wrong sender or receiver, short frames, and a few that overflow.
    task automatic send_frame();
        int          n_bytes;
        int          kind;
        logic [47:0] hdr;
        logic [7:0]  b;
        logic [15:0] sum;
        repeat ($urandom_range(0, 2)) send_word(8'($urandom), 1'b0, NOTHING);
        send_word(cfg_start, 1'b0, NOTHING);
        kind = $urandom_range(0, 99);
        if (kind < 4)
            n_bytes = $urandom_range(124, 132);
        else if (kind < 20)
            n_bytes = $urandom_range(0, 5);
        else
            n_bytes = $urandom_range(6, 24);
        hdr[47:32] = ($urandom_range(0, 9) == 0) ? 16'($urandom_range(1, 65535)) : 16'h0000;
        hdr[31:16] = ($urandom_range(0, 9) < 7) ? cfg_station : 16'($urandom);
        hdr[15:0]  = ($urandom_range(0, 9) < 3) ? cfg_rdcmd : 16'($urandom);
        for (int i = 0; i < n_bytes; i++) begin
            b = (i < 6) ? hdr[47 - 8 * i -: 8] : 8'($urandom);
            send_hex_byte(b);
        end
        // lone high nibble before the end character
        if ($urandom_range(0, 9) == 0) send_word(hex_char(4'($urandom)), 1'b0, NOTHING);
        send_word(cfg_end, 1'b0, NOTHING);
        sum = 16'($urandom);
        send_hex_byte(sum[15:8]);
        send_hex_byte(sum[7:0]);
    endtask

    // Drop valid, wait for every outstanding result, then let the pipe settle.
    task automatic drain_results();
        s_tvalid = 1'b0;
        while (due_results.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
        @(negedge aclk);
    endtask

    task automatic write_reg(input reg_idx_t idx, input logic [15:0] value);
        cfg_valid = 1'b1;
        cfg_index = idx;
        cfg_data  = value;
        do @(posedge aclk); while (!cfg_ready);
        case (idx)
            REG_START_CHAR: cfg_start   = value[7:0];
            REG_END_CHAR:   cfg_end     = value[7:0];
            REG_STATION:    cfg_station = value;
            REG_RD_CMD:     cfg_rdcmd   = value;
            default: ;
        endcase
        @(negedge aclk);
        cfg_valid = 1'b0;
    endtask

    initial begin
        // Hold every input at a known value through reset
        aresetn      = 1'b0;
        s_tvalid     = 1'b0;
        s_tdata      = 8'h00;
        cfg_valid    = 1'b0;
        cfg_index    = REG_START_CHAR;
        cfg_data     = 16'h0000;
        mismatches   = 0;
        chars_counted = 0;
        quiet_tail   = 1'b0;
        tx_idle_pct  = 20;
        rx_stall_pct = 5;
        // Predictor starts from the reset state
        fr_phase     = PH_HUNT;
        nib_held     = 1'b0;
        hi_nib       = 4'h0;
        pay_count    = 8'd0;
        sum_half     = 1'b0;
        sum_high     = 8'h00;
        cfg_start    = RST_START_CHAR;
        cfg_end      = RST_END_CHAR;
        cfg_station  = 16'h0000;
        cfg_rdcmd    = 16'h0000;
        repeat (6) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // Directed table under the reset registers
        for (int r = 0; r < N_DIRECTED; r++)
            send_word(DIRECTED_ROWS[r].ch, DIRECTED_ROWS[r].typed, DIRECTED_ROWS[r].want);

        // Random frames, one register setting per phase
        phase_no = 0;
        while (chars_counted < ITEM_TARGET) begin
            // sender holds off here until every expected result is in
            drain_results();
            case (phase_no)
                0: begin
                    new_start = 8'h00; new_end = 8'hFF;
                    new_station = 16'h0000; new_rdcmd = 16'hFFFF;
                end
                1: begin
                    new_start = 8'hFF; new_end = 8'h00;
                    new_station = 16'hFFFF; new_rdcmd = 16'h0000;
                end
                2: begin
                    new_start = RST_START_CHAR; new_end = RST_END_CHAR;
                    new_station = 16'($urandom); new_rdcmd = 16'($urandom);
                end
                3: begin
                    // end character is a digit, so it is always taken as data
                    new_start = 8'h3A; new_end = 8'h37;
                    new_station = 16'h0000; new_rdcmd = 16'h0000;
                end
                default: begin
                    new_start   = 8'($urandom);
                    new_end     = 8'($urandom);
                    new_station = $urandom_range(0, 1) ? 16'($urandom)
                                                       : 16'($urandom_range(0, 3));
                    new_rdcmd   = 16'($urandom);
                end
            endcase
            write_reg(REG_START_CHAR, {8'h00, new_start});
            write_reg(REG_END_CHAR, {8'h00, new_end});
            write_reg(REG_STATION, new_station);
            write_reg(REG_RD_CMD, new_rdcmd);
            if (!quiet_tail) begin
                case ($urandom_range(0, 2))
                    0: begin tx_idle_pct = 0;  rx_stall_pct = 0; end
                    1: begin tx_idle_pct = 10; rx_stall_pct = 3; end
                    default: begin tx_idle_pct = 35; rx_stall_pct = 15; end
                endcase
            end
            phase_base = chars_counted;
            while (chars_counted < phase_base + PHASE_ITEMS && chars_counted < ITEM_TARGET) begin
                // last stretch of the run: full rate on both sides
                if (!quiet_tail && chars_counted >= ITEM_TARGET - QUIET_ITEMS) begin
                    quiet_tail   = 1'b1;
                    tx_idle_pct  = 0;
                    rx_stall_pct = 0;
                end
                send_frame();
            end
            phase_no++;
        end

        drain_results();
        repeat (10) @(posedge aclk);
        if (mismatches == 0 && due_results.size() == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
